[hdl/b64sd_pkg.sv]
package b64sd_pkg;

  // Widths of one symbol and of the partial quad
  localparam int unsigned SymW  = 6;
  localparam int unsigned QuadW = 3 * SymW;
  localparam int unsigned WordW = 4 * SymW;

  // Character codes
  localparam logic [7:0] PadChar    = 8'h3D;  // '='
  localparam logic [7:0] PlusChar   = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar  = 8'h2F;  // '/'
  localparam logic [7:0] MinusChar  = 8'h2D;  // '-'
  localparam logic [7:0] UnderChar  = 8'h5F;  // '_'
  localparam logic [7:0] UpperFirst = 8'h41;  // 'A'
  localparam logic [7:0] UpperLast  = 8'h5A;  // 'Z'
  localparam logic [7:0] LowerFirst = 8'h61;  // 'a'
  localparam logic [7:0] LowerLast  = 8'h7A;  // 'z'
  localparam logic [7:0] DigitFirst = 8'h30;  // '0'
  localparam logic [7:0] DigitLast  = 8'h39;  // '9'

  // Symbol values at the start of each character range
  localparam logic [SymW-1:0] LowerBase = 6'd26;
  localparam logic [SymW-1:0] DigitBase = 6'd52;
  localparam logic [SymW-1:0] Sym62     = 6'd62;
  localparam logic [SymW-1:0] Sym63     = 6'd63;

  typedef enum logic {
    AlphStd = 1'b0,
    AlphUrl = 1'b1
  } alphabet_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoSymbol = 2'd1,
    StatusBadPad   = 2'd2
  } status_e;

  // Decoded character
  typedef struct packed {
    logic [SymW-1:0] value;
    logic            valid;
    logic            pad;
  } sym_t;

endpackage

[hdl/b64sd_sym_map.sv]
module b64sd_sym_map (
  input  logic [7:0]          char_i,
  input  b64sd_pkg::alphabet_e alph_i,
  output b64sd_pkg::sym_t     sym_o
);

  logic [7:0] upper_off;
  logic [7:0] lower_off;
  logic [7:0] digit_off;

  assign upper_off = char_i - b64sd_pkg::UpperFirst;
  assign lower_off = char_i - b64sd_pkg::LowerFirst;
  assign digit_off = char_i - b64sd_pkg::DigitFirst;

  // Map one character to its 6-bit value; '=' maps to zero and flags a pad
  always_comb begin
    sym_o.value = '0;
    sym_o.valid = 1'b1;
    sym_o.pad   = 1'b0;
    if (char_i >= b64sd_pkg::UpperFirst && char_i <= b64sd_pkg::UpperLast) begin
      sym_o.value = upper_off[b64sd_pkg::SymW-1:0];
    end else if (char_i >= b64sd_pkg::LowerFirst && char_i <= b64sd_pkg::LowerLast) begin
      sym_o.value = lower_off[b64sd_pkg::SymW-1:0] + b64sd_pkg::LowerBase;
    end else if (char_i >= b64sd_pkg::DigitFirst && char_i <= b64sd_pkg::DigitLast) begin
      sym_o.value = digit_off[b64sd_pkg::SymW-1:0] + b64sd_pkg::DigitBase;
    end else if (alph_i == b64sd_pkg::AlphStd && char_i == b64sd_pkg::PlusChar) begin
      sym_o.value = b64sd_pkg::Sym62;
    end else if (alph_i == b64sd_pkg::AlphStd && char_i == b64sd_pkg::SlashChar) begin
      sym_o.value = b64sd_pkg::Sym63;
    end else if (alph_i == b64sd_pkg::AlphUrl && char_i == b64sd_pkg::MinusChar) begin
      sym_o.value = b64sd_pkg::Sym62;
    end else if (alph_i == b64sd_pkg::AlphUrl && char_i == b64sd_pkg::UnderChar) begin
      sym_o.value = b64sd_pkg::Sym63;
    end else if (char_i == b64sd_pkg::PadChar) begin
      sym_o.pad = 1'b1;
    end else begin
      sym_o.valid = 1'b0;
    end
  end

endmodule

[hdl/base64_stream_decoder_unit.sv]
// The first result of a request is offered in the cycle after it is accepted. One
// character per cycle is taken while the output accepts and each yields at most one
// result; a character that completes a quad yields up to three bytes, which leave
// the result register one per cycle as the output accepts, and the input waits until
// the last byte leaves. Reset clears the decode state and the alphabet.
module base64_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: alphabet_select
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // Input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  logic       s_axis_tlast_i,   // end_of_input
  // Output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic [2:0] m_axis_tuser_o,   // [0] byte_valid, [2:1] status
  output logic       m_axis_tlast_o    // message_end
);

  localparam int unsigned SymW  = b64sd_pkg::SymW;
  localparam int unsigned QuadW = b64sd_pkg::QuadW;
  localparam int unsigned WordW = b64sd_pkg::WordW;

  b64sd_pkg::alphabet_e alph_q;

  logic [QuadW-1:0] quad_q, quad_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [2:0]       pad_q, pad_d;
  logic             fin_q, fin_d;
  logic             seen_q, seen_d;

  logic [WordW-1:0]    res_data_q, res_data_d;
  logic [1:0]          res_left_q, res_left_d;
  logic                res_bvalid_q, res_bvalid_d;
  logic                res_end_q, res_end_d;
  b64sd_pkg::status_e  res_status_q, res_status_d;

  b64sd_pkg::sym_t sym;

  logic             in_acc;
  logic             out_acc;
  logic             take;
  logic             full;
  logic             fill;
  logic             quad_done;
  logic             bad;
  logic [2:0]       pc1;
  logic [1:0]       cnt1;
  logic [QuadW-1:0] quad1;
  logic [2:0]       pad1;
  logic             seen1;
  logic             fin1;
  logic [1:0]       fill_pads;
  logic [2:0]       tot;
  logic [2:0]       pad_fin;
  logic [WordW-1:0] bits;
  logic [1:0]       nbytes;
  logic             last_res;

  b64sd_sym_map u_sym_map (
    .char_i (s_axis_tdata_i),
    .alph_i (alph_q),
    .sym_o  (sym)
  );

  // Handshakes: take a new request once the last pending result leaves
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (res_left_q == 2'd0) || (res_left_q == 2'd1 && m_axis_tready_i);

  // Feed the received symbol into the quad
  always_comb begin
    take  = sym.valid && !fin_q;
    pc1   = pad_q + {2'b00, take && sym.pad};
    full  = take && (cnt_q == 2'd3);
    cnt1  = take ? cnt_q + 2'd1 : cnt_q;
    pad1  = take ? pc1 : pad_q;
    seen1 = seen_q || take;
    if (full) begin
      quad1 = '0;
    end else if (take) begin
      quad1 = {quad_q[QuadW-SymW-1:0], sym.value};
    end else begin
      quad1 = quad_q;
    end
  end

  // Complete a quad, either with the received symbol or with implicit pads at the end
  always_comb begin
    fill      = s_axis_tlast_i && !fin_q && !full && (cnt1 != 2'd0);
    fill_pads = 2'd0 - cnt1;
    quad_done = full || fill;
    tot       = full ? pc1 : pad1 + {1'b0, fill_pads};
    case (cnt1)
      2'd1:    bits = {quad1[SymW-1:0], {(3*SymW){1'b0}}};
      2'd2:    bits = {quad1[2*SymW-1:0], {(2*SymW){1'b0}}};
      2'd3:    bits = {quad1, {SymW{1'b0}}};
      default: bits = '0;
    endcase
    if (full) begin
      bits = {quad_q, sym.value};
    end
    bad     = quad_done && (tot > 3'd2);
    nbytes  = (quad_done && !bad) ? 2'(3'd3 - tot) : 2'd0;
    fin1    = fin_q || (quad_done && tot != 3'd0);
    pad_fin = quad_done ? tot : pad1;
  end

  // Next decode state; end of message returns it to reset
  always_comb begin
    quad_d = quad_q;
    cnt_d  = cnt_q;
    pad_d  = pad_q;
    fin_d  = fin_q;
    seen_d = seen_q;
    if (in_acc) begin
      if (s_axis_tlast_i) begin
        quad_d = '0;
        cnt_d  = '0;
        pad_d  = '0;
        fin_d  = 1'b0;
        seen_d = 1'b0;
      end else begin
        quad_d = quad1;
        cnt_d  = cnt1;
        pad_d  = pad_fin;
        fin_d  = fin1;
        seen_d = seen1;
      end
    end
  end

  // Load the result register on a request, shift out one byte per output request
  always_comb begin
    res_data_d   = res_data_q;
    res_left_d   = res_left_q;
    res_bvalid_d = res_bvalid_q;
    res_end_d    = res_end_q;
    res_status_d = res_status_q;
    if (in_acc) begin
      res_data_d   = (nbytes != 2'd0) ? bits : '0;
      res_bvalid_d = (nbytes != 2'd0);
      res_end_d    = s_axis_tlast_i;
      res_left_d   = (s_axis_tlast_i && nbytes == 2'd0) ? 2'd1 : nbytes;
      if (!seen1) begin
        res_status_d = b64sd_pkg::StatusNoSymbol;
      end else if (fin1 && pad_fin > 3'd2) begin
        res_status_d = b64sd_pkg::StatusBadPad;
      end else begin
        res_status_d = b64sd_pkg::StatusOk;
      end
    end else if (out_acc) begin
      res_data_d = {res_data_q[WordW-9:0], 8'h00};
      res_left_d = res_left_q - 2'd1;
    end
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alph_q       <= b64sd_pkg::AlphStd;
      quad_q       <= '0;
      cnt_q        <= '0;
      pad_q        <= '0;
      fin_q        <= 1'b0;
      seen_q       <= 1'b0;
      res_left_q   <= '0;
      res_bvalid_q <= 1'b0;
      res_end_q    <= 1'b0;
      res_status_q <= b64sd_pkg::StatusOk;
    end else begin
      if (cfg_we_i) begin
        alph_q <= b64sd_pkg::alphabet_e'(cfg_wdata_i);
      end
      quad_q       <= quad_d;
      cnt_q        <= cnt_d;
      pad_q        <= pad_d;
      fin_q        <= fin_d;
      seen_q       <= seen_d;
      res_left_q   <= res_left_d;
      res_bvalid_q <= res_bvalid_d;
      res_end_q    <= res_end_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q <= res_data_d;
  end

  // Output ports
  assign last_res        = res_end_q && (res_left_q == 2'd1);
  assign m_axis_tvalid_o = (res_left_q != 2'd0);
  assign m_axis_tdata_o  = res_data_q[WordW-1:WordW-8];
  assign m_axis_tlast_o  = last_res;
  assign m_axis_tuser_o  = {(last_res ? res_status_q : b64sd_pkg::StatusOk), res_bvalid_q};

  // Assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_left_q > 2'd1) |-> !s_axis_tready_o)
    else $error("input accepted while several results pending");

  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tuser_o[2:1] == b64sd_pkg::StatusOk))
    else $error("status set on a result that does not end the message");

  a_nosym_nobyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2:1] == b64sd_pkg::StatusNoSymbol) |-> !m_axis_tuser_o[0])
    else $error("byte emitted in a message without symbols");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (cnt_q == 2'd0 && !fin_q && !seen_q))
    else $error("decode state not cleared after end of message");

endmodule
